@@ rtl/kvclp_pkg.sv @@
// kvclp_pkg: types, codes and verb tables for the command line parser
// used by kvclp_core, kvclp_skid and kv_command_line_parser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kvclp_pkg;

    localparam int NUM_VERBS = 9;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [3:0] POS_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_VERB    = 3'd1,
        PH_PRE_KEY = 3'd2,
        PH_KEY     = 3'd3,
        PH_PRE_VAL = 3'd4,
        PH_VALUE   = 3'd5,
        PH_IGNORE  = 3'd6,
        PH_UNKNOWN = 3'd7
    } t_phase;

    localparam logic [3:0] CMD_INVALID  = 4'd0;
    localparam logic [3:0] CMD_LAST_BARE = 4'd6;
    localparam logic [3:0] CMD_SET      = 4'd9;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_EMPTY         = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN_VERB  = 3'd2;
    localparam logic [2:0] ERR_MISSING_KEY   = 3'd3;
    localparam logic [2:0] ERR_MISSING_VALUE = 3'd4;

    localparam logic [1:0] ROLE_OTHER = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    typedef logic [NUM_VERBS-1:0] t_cand;

    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] role;
        logic       line_done;
        logic [3:0] command;
        logic [2:0] error_code;
    } t_result;

    localparam logic [3:0] VERB_LEN [NUM_VERBS] = '{
        4'd5, 4'd7, 4'd5, 4'd6, 4'd8, 4'd4, 4'd3, 4'd3, 4'd3
    };

    // text left-aligned, first character in the top byte
    localparam logic [63:0] VERB_TEXT [NUM_VERBS] = '{
        {"STATS", 24'd0},
        {"COMPACT", 8'd0},
        {"BEGIN", 24'd0},
        {"COMMIT", 16'd0},
        "ROLLBACK",
        {"QUIT", 32'd0},
        {"GET", 40'd0},
        {"DEL", 40'd0},
        {"SET", 40'd0}
    };

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [7:0] verb_char(input int v, input logic [2:0] p);
        logic [63:0] txt;
        txt = VERB_TEXT[v];
        return txt[(3'd7 - p) * 8 +: 8];
    endfunction

    // lowest set bit wins
    function automatic logic [3:0] code_of(input t_cand v);
        logic [3:0] code;
        code = CMD_INVALID;
        for (int i = NUM_VERBS - 1; i >= 0; i--) begin
            if (v[i]) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic t_cand resolve(input t_cand cand, input logic [3:0] pos);
        t_cand hit;
        hit = '0;
        for (int i = 0; i < NUM_VERBS; i++) begin
            if (cand[i] && VERB_LEN[i] == pos) begin
                hit = t_cand'(1) << i;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kv_command_line_parser.sv @@
// kv_command_line_parser: top level, parse core feeding a skid-buffered result register
// depends on kvclp_pkg, kvclp_core and kvclp_skid
`timescale 1ns / 1ps
`default_nettype none

// Parses one text command line delivered a byte per word, last word marked by
// i_end_of_line; a word with i_no_char set carries nothing to parse. Every input word
// gives exactly one registered result word: the byte echoed, its role (key or
// value byte), and on the line's last word the command and error code. One word is
// taken per clock while o_stall is low; the only loop is the phase/verb-match state
// update. A result register with one skid word behind it keeps input flowing while
// the output is stalled; o_stall rises only when both are full.
module kv_command_line_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_no_char,
    input  wire logic       i_end_of_line,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_char_out,
    output logic [1:0]      o_role,
    output logic            o_line_done,
    output logic [3:0]      o_command,
    output logic [2:0]      o_error_code
);
    import kvclp_pkg::*;

    t_result core_res, out_res;
    logic    accept;

    assign accept = i_valid && !o_stall;

    kvclp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_byte   (i_char_byte),
        .i_no_char     (i_no_char),
        .i_end_of_line (i_end_of_line),
        .o_result      (core_res)
    );

    kvclp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (core_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_res)
    );

    assign o_char_out   = out_res.char_out;
    assign o_role       = out_res.role;
    assign o_line_done  = out_res.line_done;
    assign o_command    = out_res.command;
    assign o_error_code = out_res.error_code;

endmodule

`default_nettype wire

@@ rtl/kvclp_core.sv @@
// kvclp_core: parse state registers and the per-word decode logic
// depends on kvclp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kvclp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_char_byte,
    input  wire logic              i_no_char,
    input  wire logic              i_end_of_line,
    output kvclp_pkg::t_result     o_result
);
    import kvclp_pkg::*;

    t_phase      r_phase, n_phase, s_phase;
    t_cand       r_cand, n_cand, s_cand;
    logic [3:0]  r_pos, n_pos, s_pos;
    logic [1:0]  s_role;
    logic [3:0]  s_command;
    logic [2:0]  s_error;
    logic        sp;
    logic [7:0]  up;
    t_cand       hit_now;
    logic [3:0]  code_now;

    assign sp = (i_char_byte == CHAR_SPACE);
    assign up = fold(i_char_byte);
    assign hit_now = resolve(r_cand, r_pos);
    assign code_now = code_of(hit_now);

    // state after the character itself
    always_comb begin
        s_phase = r_phase;
        s_cand  = r_cand;
        s_pos   = r_pos;
        s_role  = ROLE_OTHER;
        if (!i_no_char) begin
            unique case (r_phase)
                PH_LEAD, PH_VERB: begin
                    if (r_phase == PH_VERB || !sp) begin
                        s_phase = PH_VERB;
                        if (!sp) begin
                            for (int i = 0; i < NUM_VERBS; i++) begin
                                if (r_pos >= VERB_LEN[i] || verb_char(i, r_pos[2:0]) != up) begin
                                    s_cand[i] = 1'b0;
                                end
                            end
                            if (r_pos < POS_MAX) begin
                                s_pos = r_pos + 4'd1;
                            end
                        end else begin
                            s_cand = hit_now;
                            if (code_now == CMD_INVALID) begin
                                s_phase = PH_UNKNOWN;
                            end else if (code_now <= CMD_LAST_BARE) begin
                                s_phase = PH_IGNORE;
                            end else begin
                                s_phase = PH_PRE_KEY;
                            end
                        end
                    end
                end
                PH_PRE_KEY, PH_KEY: begin
                    if (r_phase == PH_KEY || !sp) begin
                        s_phase = PH_KEY;
                        if (!sp) begin
                            s_role = ROLE_KEY;
                        end else begin
                            s_phase = (code_of(r_cand) == CMD_SET) ? PH_PRE_VAL : PH_IGNORE;
                        end
                    end
                end
                PH_PRE_VAL, PH_VALUE: begin
                    if (r_phase == PH_VALUE || !sp) begin
                        s_phase = PH_VALUE;
                        s_role  = ROLE_VALUE;
                    end
                end
                PH_IGNORE, PH_UNKNOWN: begin
                end
            endcase
        end
    end

    // line end verdict
    always_comb begin
        logic [3:0] code_end;
        code_end  = code_of(resolve(s_cand, s_pos));
        s_command = CMD_INVALID;
        s_error   = ERR_NONE;
        if (i_end_of_line) begin
            unique case (s_phase)
                PH_LEAD: s_error = ERR_EMPTY;
                PH_VERB: begin
                    if (code_end == CMD_INVALID) begin
                        s_error = ERR_UNKNOWN_VERB;
                    end else if (code_end <= CMD_LAST_BARE) begin
                        s_command = code_end;
                    end else begin
                        s_error = ERR_MISSING_KEY;
                    end
                end
                PH_PRE_KEY: s_error = ERR_MISSING_KEY;
                PH_KEY: begin
                    if (code_of(s_cand) == CMD_SET) begin
                        s_error = ERR_MISSING_VALUE;
                    end else begin
                        s_command = code_of(s_cand);
                    end
                end
                PH_PRE_VAL: s_error = ERR_MISSING_VALUE;
                PH_VALUE:   s_command = CMD_SET;
                PH_IGNORE:  s_command = code_of(s_cand);
                PH_UNKNOWN: s_error = ERR_UNKNOWN_VERB;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cand  = r_cand;
        n_pos   = r_pos;
        if (i_accept) begin
            if (i_end_of_line) begin
                n_phase = PH_LEAD;
                n_cand  = '1;
                n_pos   = '0;
            end else begin
                n_phase = s_phase;
                n_cand  = s_cand;
                n_pos   = s_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_cand  <= '1;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
        end
    end

    assign o_result.char_out   = i_char_byte;
    assign o_result.role       = s_role;
    assign o_result.line_done  = i_end_of_line;
    assign o_result.command    = s_command;
    assign o_result.error_code = s_error;

endmodule

`default_nettype wire

@@ rtl/kvclp_skid.sv @@
// kvclp_skid: result register with a skid word behind it
// depends on kvclp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kvclp_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  kvclp_pkg::t_result     i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output kvclp_pkg::t_result     o_data
);
    import kvclp_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take, acc;

    assign take    = r_out_valid && !i_stall;
    assign acc     = i_valid && !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (acc) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (acc) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for kv_command_line_parser, byte stream of text lines in,
// tagged bytes and per-line command/error words out; uses kvclp_pkg and the rtl top only
`timescale 1ns / 1ps

module tb_top;
    import kvclp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int WORDS_PER_HALF = 150;
    localparam int NUM_PHASES = 4;
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 86, 0, 20};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 86, 20};

    typedef struct packed {
        logic [7:0] ch;
        logic       none;
        logic       eol;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_char_byte = '0;
    logic       i_no_char = 1'b0;
    logic       i_end_of_line = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_char_out;
    logic [1:0] o_role;
    logic       o_line_done;
    logic [3:0] o_command;
    logic [2:0] o_error_code;

    string verb_names [NUM_VERBS] = '{
        "STATS", "COMPACT", "BEGIN", "COMMIT", "ROLLBACK", "QUIT", "GET", "DEL", "SET"
    };

    t_word      pending_words [$];
    t_result    expected_results [$];
    logic [7:0] line_buf [$];
    int         words_queued = 0;
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // parser state as the block should hold it
    t_phase     line_phase;
    t_cand      verb_match;
    logic [3:0] verb_len_seen;

    kv_command_line_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_byte   (i_char_byte),
        .i_no_char     (i_no_char),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_out    (o_char_out),
        .o_role        (o_role),
        .o_line_done   (o_line_done),
        .o_command     (o_command),
        .o_error_code  (o_error_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        line_phase = PH_LEAD;
        verb_match = '1;
        verb_len_seen = '0;
    endfunction

    // lowest matching verb gives the command code
    function automatic logic [3:0] command_of(t_cand v);
        logic [3:0] code;
        code = CMD_INVALID;
        for (int i = NUM_VERBS - 1; i >= 0; i--) begin
            if (v[i]) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [3:0] close_verb();
        t_cand hit;
        hit = '0;
        for (int i = 0; i < NUM_VERBS; i++) begin
            if (verb_match[i] && verb_names[i].len() == int'(verb_len_seen)) begin
                hit = t_cand'(1) << i;
            end
        end
        verb_match = hit;
        return command_of(hit);
    endfunction

    function automatic t_result parse_word(logic [7:0] c, logic none, logic eol);
        t_result    r;
        logic [7:0] u;
        logic [3:0] code;
        logic       sp;
        r = '0;
        r.char_out = c;
        r.line_done = eol;
        r.role = ROLE_OTHER;
        r.command = CMD_INVALID;
        r.error_code = ERR_NONE;
        sp = (c == CHAR_SPACE);
        u = (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
        if (!none) begin
            if (!sp) begin
                if (line_phase == PH_LEAD) begin
                    line_phase = PH_VERB;
                end else if (line_phase == PH_PRE_KEY) begin
                    line_phase = PH_KEY;
                end else if (line_phase == PH_PRE_VAL) begin
                    line_phase = PH_VALUE;
                end
            end
            case (line_phase)
                PH_VERB: begin
                    if (!sp) begin
                        for (int i = 0; i < NUM_VERBS; i++) begin
                            if (int'(verb_len_seen) >= verb_names[i].len() ||
                                    verb_names[i][verb_len_seen] != u) begin
                                verb_match[i] = 1'b0;
                            end
                        end
                        if (verb_len_seen != POS_MAX) begin
                            verb_len_seen = verb_len_seen + 4'd1;
                        end
                    end else begin
                        code = close_verb();
                        if (code == CMD_INVALID) begin
                            line_phase = PH_UNKNOWN;
                        end else if (code <= CMD_LAST_BARE) begin
                            line_phase = PH_IGNORE;
                        end else begin
                            line_phase = PH_PRE_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    if (!sp) begin
                        r.role = ROLE_KEY;
                    end else begin
                        line_phase = (command_of(verb_match) == CMD_SET) ? PH_PRE_VAL : PH_IGNORE;
                    end
                end
                PH_VALUE: r.role = ROLE_VALUE;
                default: ;
            endcase
        end
        if (eol) begin
            case (line_phase)
                PH_LEAD: r.error_code = ERR_EMPTY;
                PH_VERB: begin
                    code = close_verb();
                    if (code == CMD_INVALID) begin
                        r.error_code = ERR_UNKNOWN_VERB;
                    end else if (code <= CMD_LAST_BARE) begin
                        r.command = code;
                    end else begin
                        r.error_code = ERR_MISSING_KEY;
                    end
                end
                PH_PRE_KEY: r.error_code = ERR_MISSING_KEY;
                PH_KEY: begin
                    code = command_of(verb_match);
                    if (code == CMD_SET) begin
                        r.error_code = ERR_MISSING_VALUE;
                    end else begin
                        r.command = code;
                    end
                end
                PH_PRE_VAL: r.error_code = ERR_MISSING_VALUE;
                PH_VALUE: r.command = CMD_SET;
                PH_IGNORE: r.command = command_of(verb_match);
                default: r.error_code = ERR_UNKNOWN_VERB;
            endcase
            clear_parser();
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic queue_word(logic [7:0] ch, logic none, logic eol);
        t_word w;
        w.ch = ch;
        w.none = none;
        w.eol = eol;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    task automatic put_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            line_buf.insert(line_buf.size(), s[k]);
        end
    endtask

    task automatic put_spaces(int lo, int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) line_buf.insert(line_buf.size(), CHAR_SPACE);
    endtask

    task automatic put_verb(int v, int n);
        logic [7:0] ch;
        for (int k = 0; k < n; k++) begin
            ch = verb_names[v][k];
            if ($urandom_range(1, 0) == 1) begin
                ch = ch + CASE_OFFSET;
            end
            line_buf.insert(line_buf.size(), ch);
        end
    endtask

    task automatic put_junk(int lo, int hi, bit spaces_ok);
        int         n;
        logic [7:0] ch;
        n = $urandom_range(hi, lo);
        repeat (n) begin
            if ($urandom_range(1, 0) == 1) begin
                ch = 8'($urandom_range(25, 0)) + ($urandom_range(1, 0) ? "a" : "A");
            end else begin
                ch = 8'($urandom);
            end
            if (!spaces_ok && ch == CHAR_SPACE) begin
                ch = "_";
            end
            line_buf.insert(line_buf.size(), ch);
        end
    endtask

    // turn the buffered bytes into words, optionally sprinkling empty words
    task automatic flush_line(bit scatter, bit ends);
        bit tail;
        tail = ends && (line_buf.size() == 0 || (scatter && $urandom_range(7, 0) == 0));
        foreach (line_buf[k]) begin
            if (scatter && $urandom_range(19, 0) == 0) begin
                queue_word(8'($urandom), 1'b1, 1'b0);
            end
            queue_word(line_buf[k], 1'b0, ends && !tail && k == line_buf.size() - 1);
        end
        if (tail) begin
            queue_word(8'($urandom), 1'b1, 1'b1);
        end
        line_buf.delete();
    endtask

    task automatic random_line();
        int kind;
        int v;
        kind = $urandom_range(99, 0);
        if (kind < 5) begin
            put_spaces(0, 3);
            flush_line(1'b1, 1'b1);
            return;
        end
        put_spaces(0, 2);
        v = $urandom_range(NUM_VERBS - 1, 0);
        if (kind < 80) begin
            put_verb(v, verb_names[v].len());
        end else if (kind < 87) begin
            put_verb(v, $urandom_range(verb_names[v].len() - 1, 1));
        end else if (kind < 93) begin
            put_verb(v, verb_names[v].len());
            put_junk(1, 8, 1'b0);
        end else begin
            put_junk(1, 18, 1'b0);
        end
        if ($urandom_range(9, 0) != 0) begin
            put_spaces(1, 3);
            if ($urandom_range(9, 0) != 0) begin
                put_junk(1, 6, 1'b0);
                if ($urandom_range(9, 0) != 0) begin
                    put_spaces(1, 3);
                    if ($urandom_range(9, 0) != 0) begin
                        put_junk(1, 8, 1'b1);
                    end
                end
            end
        end
        flush_line(1'b1, 1'b1);
    endtask

    // sampled away from the rising edge so that every update has settled
    task automatic drain_all();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : drive
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_parser();
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.insert(expected_results.size(),
                    parse_word(i_char_byte, i_no_char, i_end_of_line));
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_char_byte <= w.ch;
                    i_no_char <= w.none;
                    i_end_of_line <= w.eol;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.char_out = o_char_out;
                got.role = o_role;
                got.line_done = o_line_done;
                got.command = o_command;
                got.error_code = o_error_code;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, char %0h", o_char_out));
                end else begin
                    want = expected_results.pop_front();
                    check_field("char_out", got.char_out, want.char_out);
                    check_field("role", 8'(got.role), 8'(want.role));
                    check_field("line_done", 8'(got.line_done), 8'(want.line_done));
                    check_field("command", 8'(got.command), 8'(want.command));
                    check_field("error_code", 8'(got.error_code), 8'(want.error_code));
                end
            end
            i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int half_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty line, line of spaces, bare verb, key with a high byte, set lacking value,
        // over-long verb, set with spaced value and an empty word inside
        flush_line(1'b0, 1'b1);
        put_text("  ");
        flush_line(1'b0, 1'b1);
        put_text("Quit");
        flush_line(1'b0, 1'b1);
        put_text(" get ");
        line_buf.insert(line_buf.size(), 8'he9);
        flush_line(1'b0, 1'b1);
        put_text("SeT a");
        flush_line(1'b0, 1'b1);
        put_text("ROLLBACKS");
        flush_line(1'b0, 1'b1);
        put_text("set k");
        flush_line(1'b0, 1'b0);
        queue_word(8'ha5, 1'b1, 1'b0);
        put_text(" v w");
        flush_line(1'b0, 1'b1);
        drain_all();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int h = 0; h < 2; h++) begin
                half_end = words_queued + WORDS_PER_HALF;
                while (words_queued < half_end) begin
                    random_line();
                    while (pending_words.size() > 16) begin
                        @(posedge i_clk);
                    end
                end
                drain_all();
            end
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
